// ===== hw/rtl/i2cmw_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine package
// Shared types and constants for the front end, the queue and the bus engine.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

   localparam int unsigned FIFO_DEPTH_DEFAULT = 4;
   localparam logic [15:0] HALF_PERIOD_RESET  = 16'd50;
   localparam logic [7:0]  SHIFT_IDLE         = 8'hFF;

   // Opcodes on the request channel.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // Status codes on the response channel.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NACK      = 2'd1;
   localparam logic [1:0] STATUS_NO_START  = 2'd2;
   localparam logic [1:0] STATUS_NO_STOP   = 2'd3;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   // One classified word as it travels through the queue.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] tx_byte;
      logic       scl;
      logic       sda;
   } item_type;

   typedef enum logic [9:0] {
      PH_IDLE       = 10'b00_0000_0001,
      PH_START_HOLD = 10'b00_0000_0010,
      PH_START_LOW  = 10'b00_0000_0100,
      PH_BIT_HIGH   = 10'b00_0000_1000,
      PH_BIT_LOW    = 10'b00_0001_0000,
      PH_ACK_HIGH   = 10'b00_0010_0000,
      PH_ACK_LOW    = 10'b00_0100_0000,
      PH_STOP_LOW   = 10'b00_1000_0000,
      PH_STOP_HIGH  = 10'b01_0000_0000,
      PH_STOP_CHECK = 10'b10_0000_0000
   } phase_type;

endpackage

// ===== hw/rtl/i2c_master_write_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine
// Tick-driven I2C master transmitter: START with address, data byte writes
// with ACK sampling, STOP, clock stretching and condition checks.
//
//   channel  direction  handshake          content
//   req      in         req_valid/stall    op, address, rw, data, line samples
//   rsp      out        rsp_valid/stall    line drives, busy, done, status
//   csr      in         csr_valid/ready    half_period_ticks
//
// One word is accepted and one response produced every clock while neither
// req_stall nor rsp_stall holds the flow; the bus sequencer updates its state
// once per word. A response is registered from the queue head, so each word
// passes a queue slot and then the response register. The queue holds
// FIFO_DEPTH words, and req_stall is high exactly when it is full. Reset is
// synchronous and returns the bus to idle with both lines released.
// ----------------------------------------------------------------------------
module i2c_master_write_engine
   import i2cmw_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_slave_addr,
   input  logic        req_read_not_write,
   input  logic [7:0]  req_data_byte,
   input  logic        req_scl_in,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_release,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_half_period_ticks
);

   item_type front_item;
   item_type head_item;
   logic     fifo_full;
   logic     head_valid;
   logic     pop;

   assign req_stall = fifo_full;
   assign csr_ready = 1'b1;

   i2cmw_front u_front (
      .req_op             (req_op),
      .req_slave_addr     (req_slave_addr),
      .req_read_not_write (req_read_not_write),
      .req_data_byte      (req_data_byte),
      .req_scl_in         (req_scl_in),
      .req_sda_in         (req_sda_in),
      .item               (front_item)
   );

   i2cmw_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !req_stall),
      .push_item  (front_item),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   i2cmw_engine u_engine (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid && csr_ready),
      .csr_half_period_ticks (csr_half_period_ticks),
      .head_valid            (head_valid),
      .head_item             (head_item),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_scl_release       (rsp_scl_release),
      .rsp_sda_release       (rsp_sda_release),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_status            (rsp_status)
   );

endmodule

// ===== hw/rtl/i2cmw_front.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine front end
// Classifies each request word and builds the byte that its command sends.
// ----------------------------------------------------------------------------
module i2cmw_front
   import i2cmw_pkg::*;
(
   input  logic [1:0] req_op,
   input  logic [6:0] req_slave_addr,
   input  logic       req_read_not_write,
   input  logic [7:0] req_data_byte,
   input  logic       req_scl_in,
   input  logic       req_sda_in,
   output item_type   item
);

   always_comb begin
      item.scl = req_scl_in;
      item.sda = req_sda_in;
      case (req_op)
         OP_START: begin
            item.kind    = KIND_START;
            item.tx_byte = {req_slave_addr, req_read_not_write};
         end
         OP_WRITE: begin
            item.kind    = KIND_WRITE;
            item.tx_byte = req_data_byte;
         end
         OP_STOP: begin
            item.kind    = KIND_STOP;
            item.tx_byte = req_data_byte;
         end
         default: begin
            item.kind    = KIND_TICK;
            item.tx_byte = req_data_byte;
         end
      endcase
   end

endmodule

// ===== hw/rtl/i2cmw_fifo.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine queue
// Small first-in first-out buffer between the front end and the bus engine.
// ----------------------------------------------------------------------------
module i2cmw_fifo
   import i2cmw_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   item_type         slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/i2cmw_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine bus sequencer
// Runs the START, byte, ACK and STOP phases one queued word per cycle unless
// rsp stalls, and holds each response in an output register until taken.
// ----------------------------------------------------------------------------
module i2cmw_engine
   import i2cmw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [15:0] csr_half_period_ticks,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_release,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status
);

   logic [15:0] half_period_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic        scl_drive_ff, scl_drive_in;
   logic        sda_drive_ff, sda_drive_in;
   logic        seen_ff, seen_in;
   logic [1:0]  status_ff, status_in;
   logic        done;

   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff;
   logic [1:0]  rsp_status_ff;

   logic [15:0] limit;
   logic [15:0] tick_inc;
   logic        level_match;
   logic        elapsed;
   logic [15:0] tick_adv;
   logic [7:0]  shift_next;
   logic [3:0]  bit_next;

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // The half-period counter only advances while SCL reads the driven level,
   // which is what lets a slave stretch the clock.
   assign limit       = (half_period_ff == '0) ? 16'd1 : half_period_ff;
   assign tick_inc    = tick_count_ff + 16'd1;
   assign level_match = (head_item.scl == scl_drive_ff);
   assign elapsed     = level_match && (tick_inc >= limit);
   assign tick_adv    = !level_match ? tick_count_ff : (elapsed ? 16'd0 : tick_inc);
   assign shift_next  = {shift_ff[6:0], 1'b1};
   assign bit_next    = bit_count_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      shift_in      = shift_ff;
      bit_count_in  = bit_count_ff;
      tick_count_in = tick_count_ff;
      scl_drive_in  = scl_drive_ff;
      sda_drive_in  = sda_drive_ff;
      seen_in       = seen_ff;
      status_in     = status_ff;
      done          = 1'b0;
      if (head_item.kind != KIND_TICK) begin
         if (phase_ff == PH_IDLE) begin
            tick_count_in = '0;
            bit_count_in  = '0;
            seen_in       = 1'b0;
            status_in     = STATUS_OK;
            case (head_item.kind)
               KIND_START: begin
                  shift_in     = head_item.tx_byte;
                  scl_drive_in = 1'b1;
                  sda_drive_in = 1'b0;
                  phase_in     = PH_START_HOLD;
               end
               KIND_WRITE: begin
                  shift_in     = head_item.tx_byte;
                  scl_drive_in = 1'b0;
                  sda_drive_in = head_item.tx_byte[7];
                  phase_in     = PH_BIT_LOW;
               end
               default: begin
                  scl_drive_in = 1'b0;
                  sda_drive_in = 1'b0;
                  phase_in     = PH_STOP_LOW;
               end
            endcase
         end
      end else begin
         case (phase_ff)
            PH_START_HOLD: begin
               tick_count_in = tick_adv;
               if (head_item.scl && !head_item.sda) begin
                  seen_in = 1'b1;
               end
               if (elapsed) begin
                  scl_drive_in = 1'b0;
                  sda_drive_in = shift_ff[7];
                  phase_in     = PH_START_LOW;
               end
            end
            PH_START_LOW: begin
               tick_count_in = tick_adv;
               if (elapsed) begin
                  if (!seen_ff) begin
                     status_in    = STATUS_NO_START;
                     sda_drive_in = 1'b1;
                     done         = 1'b1;
                     phase_in     = PH_IDLE;
                  end else begin
                     scl_drive_in = 1'b1;
                     phase_in     = PH_BIT_HIGH;
                  end
               end
            end
            PH_BIT_HIGH: begin
               tick_count_in = tick_adv;
               if (elapsed) begin
                  scl_drive_in = 1'b0;
                  shift_in     = shift_next;
                  bit_count_in = bit_next;
                  sda_drive_in = (bit_next >= 4'd8) ? 1'b1 : shift_next[7];
                  phase_in     = PH_BIT_LOW;
               end
            end
            PH_BIT_LOW: begin
               tick_count_in = tick_adv;
               if (elapsed) begin
                  scl_drive_in = 1'b1;
                  phase_in     = (bit_count_ff >= 4'd8) ? PH_ACK_HIGH : PH_BIT_HIGH;
               end
            end
            PH_ACK_HIGH: begin
               tick_count_in = tick_adv;
               if (elapsed) begin
                  status_in    = head_item.sda ? STATUS_NACK : STATUS_OK;
                  scl_drive_in = 1'b0;
                  phase_in     = PH_ACK_LOW;
               end
            end
            PH_ACK_LOW: begin
               tick_count_in = tick_adv;
               if (elapsed) begin
                  bit_count_in = '0;
                  shift_in     = SHIFT_IDLE;
                  done         = 1'b1;
                  phase_in     = PH_IDLE;
               end
            end
            PH_STOP_LOW: begin
               tick_count_in = tick_adv;
               if (elapsed) begin
                  scl_drive_in = 1'b1;
                  phase_in     = PH_STOP_HIGH;
               end
            end
            PH_STOP_HIGH: begin
               tick_count_in = tick_adv;
               if (head_item.scl && !head_item.sda) begin
                  seen_in = 1'b1;
               end
               if (elapsed) begin
                  sda_drive_in = 1'b1;
                  phase_in     = PH_STOP_CHECK;
               end
            end
            PH_STOP_CHECK: begin
               // The tick after SDA is released must see both lines high.
               status_in = (seen_ff && head_item.scl && head_item.sda) ?
                           STATUS_OK : STATUS_NO_STOP;
               seen_in   = 1'b0;
               done      = 1'b1;
               phase_in  = PH_IDLE;
            end
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_valid) begin
         half_period_ff <= csr_half_period_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         shift_ff      <= SHIFT_IDLE;
         bit_count_ff  <= '0;
         tick_count_ff <= '0;
         scl_drive_ff  <= 1'b1;
         sda_drive_ff  <= 1'b1;
         seen_ff       <= 1'b0;
         status_ff     <= STATUS_OK;
      end else if (pop) begin
         phase_ff      <= phase_in;
         shift_ff      <= shift_in;
         bit_count_ff  <= bit_count_in;
         tick_count_ff <= tick_count_in;
         scl_drive_ff  <= scl_drive_in;
         sda_drive_ff  <= sda_drive_in;
         seen_ff       <= seen_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_scl_ff    <= scl_drive_in;
         rsp_sda_ff    <= sda_drive_in;
         rsp_busy_ff   <= (phase_in != PH_IDLE);
         rsp_done_ff   <= done;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_release = rsp_scl_ff;
   assign rsp_sda_release = rsp_sda_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_status      = rsp_status_ff;

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("engine advanced while a response was stalled");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff)
      else $error("finished response still reports busy");

   a_idle_counters_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_count_ff == '0 && bit_count_ff == '0))
      else $error("counters left nonzero in idle");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd8)
      else $error("bit counter ran past a byte");

endmodule

// ===== test/i2c_master_write_engine_tb.sv =====
// ----------------------------------------------------------------------------
// I2C master write engine testbench
// Sends command and tick words while a local bus predictor tracks the
// transmitter's phase, line drives and status. Every response word is
// compared against the predicted one. Tick line samples follow the predicted
// drives as an open-drain bus would, and add stretching, NACKs and noise.
// Both channels idle and stall at random, and the half period is changed
// between phases.
// ----------------------------------------------------------------------------
module i2c_master_write_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cmw_pkg::*;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [1:0] status;
   } bus_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_TICK;
   logic [6:0]  req_slave_addr = '0;
   logic        req_read_not_write = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        req_scl_in = 1'b1;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_release;
   logic        rsp_sda_release;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_half_period_ticks = HALF_PERIOD_RESET;

   // Predicted transmitter state.
   phase_type   line_phase = PH_IDLE;
   logic [7:0]  shift_bits = SHIFT_IDLE;
   logic [3:0]  bit_index = '0;
   logic [15:0] tick_total = '0;
   logic        scl_drive = 1'b1;
   logic        sda_drive = 1'b1;
   logic        cond_seen = 1'b0;
   logic [1:0]  cmd_status = STATUS_OK;
   logic [15:0] half_period = HALF_PERIOD_RESET;

   bus_view_type expected_views[$];
   int          mismatches = 0;
   int          live_items = 0;
   logic        steady = 1'b0;

   i2c_master_write_engine uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 29);
   end

   // A tick only counts toward the half period while SCL reads back at the
   // level being driven, which is how clock stretching holds the engine.
   function automatic logic half_elapsed(input logic scl);
      logic [15:0] limit;
      limit = (half_period != 16'd0) ? half_period : 16'd1;
      if (scl != scl_drive)
         return 1'b0;
      tick_total = tick_total + 16'd1;
      if (tick_total >= limit) begin
         tick_total = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bus_view_type step_engine(input logic [1:0] op, input logic [6:0] addr,
                                                input logic rw, input logic [7:0] data,
                                                input logic scl, input logic sda);
      logic done;
      done = 1'b0;
      if (op != OP_TICK) begin
         if (line_phase == PH_IDLE) begin
            tick_total = '0;
            bit_index  = '0;
            cond_seen  = 1'b0;
            cmd_status = STATUS_OK;
            case (op)
               OP_START: begin
                  shift_bits = {addr, rw};
                  scl_drive  = 1'b1;
                  sda_drive  = 1'b0;
                  line_phase = PH_START_HOLD;
               end
               OP_WRITE: begin
                  shift_bits = data;
                  scl_drive  = 1'b0;
                  sda_drive  = data[7];
                  line_phase = PH_BIT_LOW;
               end
               default: begin
                  scl_drive  = 1'b0;
                  sda_drive  = 1'b0;
                  line_phase = PH_STOP_LOW;
               end
            endcase
         end
      end else begin
         case (line_phase)
            PH_START_HOLD: begin
               if (scl && !sda)
                  cond_seen = 1'b1;
               if (half_elapsed(scl)) begin
                  scl_drive  = 1'b0;
                  sda_drive  = shift_bits[7];
                  line_phase = PH_START_LOW;
               end
            end
            PH_START_LOW: begin
               if (half_elapsed(scl)) begin
                  if (!cond_seen) begin
                     cmd_status = STATUS_NO_START;
                     sda_drive  = 1'b1;
                     done       = 1'b1;
                     line_phase = PH_IDLE;
                  end else begin
                     scl_drive  = 1'b1;
                     line_phase = PH_BIT_HIGH;
                  end
               end
            end
            PH_BIT_HIGH: begin
               if (half_elapsed(scl)) begin
                  scl_drive  = 1'b0;
                  shift_bits = {shift_bits[6:0], 1'b1};
                  bit_index  = bit_index + 4'd1;
                  sda_drive  = (bit_index >= 4'd8) ? 1'b1 : shift_bits[7];
                  line_phase = PH_BIT_LOW;
               end
            end
            PH_BIT_LOW: begin
               if (half_elapsed(scl)) begin
                  scl_drive  = 1'b1;
                  line_phase = (bit_index >= 4'd8) ? PH_ACK_HIGH : PH_BIT_HIGH;
               end
            end
            PH_ACK_HIGH: begin
               if (half_elapsed(scl)) begin
                  cmd_status = sda ? STATUS_NACK : STATUS_OK;
                  scl_drive  = 1'b0;
                  line_phase = PH_ACK_LOW;
               end
            end
            PH_ACK_LOW: begin
               if (half_elapsed(scl)) begin
                  bit_index  = '0;
                  shift_bits = SHIFT_IDLE;
                  done       = 1'b1;
                  line_phase = PH_IDLE;
               end
            end
            PH_STOP_LOW: begin
               if (half_elapsed(scl)) begin
                  scl_drive  = 1'b1;
                  line_phase = PH_STOP_HIGH;
               end
            end
            PH_STOP_HIGH: begin
               if (scl && !sda)
                  cond_seen = 1'b1;
               if (half_elapsed(scl)) begin
                  sda_drive  = 1'b1;
                  line_phase = PH_STOP_CHECK;
               end
            end
            PH_STOP_CHECK: begin
               cmd_status = (cond_seen && scl && sda) ? STATUS_OK : STATUS_NO_STOP;
               cond_seen  = 1'b0;
               done       = 1'b1;
               line_phase = PH_IDLE;
            end
            default: line_phase = PH_IDLE;
         endcase
      end
      return {scl_drive, sda_drive, line_phase != PH_IDLE, done, cmd_status};
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [6:0] addr, input logic rw,
                            input logic [7:0] data, input logic scl, input logic sda);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_slave_addr     <= addr;
      req_read_not_write <= rw;
      req_data_byte      <= data;
      req_scl_in         <= scl;
      req_sda_in         <= sda;
      do @(posedge clock); while (req_stall);
      // Ticks while idle and commands while busy leave the engine untouched.
      if ((op == OP_TICK) != (line_phase == PH_IDLE))
         live_items++;
      expected_views.push_back(step_engine(op, addr, rw, data, scl, sda));
   endtask

   task automatic send_random_word(input logic [1:0] op);
      send_word(op, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Line samples as an open-drain bus would read them: the slave pulls SDA
   // for the acknowledge, may hold SCL low, and noise replaces both at random.
   task automatic send_tick(input int stretch_pct, input logic nack, input int noise_pct);
      logic scl;
      logic sda;
      scl = scl_drive;
      sda = sda_drive & ((line_phase == PH_ACK_HIGH) ? nack : 1'b1);
      if (scl_drive && $urandom_range(0, 99) < stretch_pct)
         scl = 1'b0;
      if ($urandom_range(0, 99) < noise_pct) begin
         scl = 1'($urandom);
         sda = 1'($urandom);
      end
      send_word(OP_TICK, 7'($urandom), 1'($urandom), 8'($urandom), scl, sda);
   endtask

   task automatic finish_command(input int stretch_pct, input logic nack, input int noise_pct);
      while (line_phase != PH_IDLE)
         send_tick(stretch_pct, nack, noise_pct);
   endtask

   task automatic set_half_period(input logic [15:0] value);
      finish_command(0, 1'b0, 0);
      req_valid <= 1'b0;
      while (expected_views.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid             <= 1'b1;
      csr_half_period_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      half_period = value;
   endtask

   task automatic test_idle_lines;
      send_word(OP_TICK, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0);
      send_word(OP_TICK, 7'h7F, 1'b1, 8'hFF, 1'b0, 1'b1);
      send_word(OP_TICK, 7'h00, 1'b1, 8'h00, 1'b1, 1'b0);
      send_word(OP_TICK, 7'h7F, 1'b0, 8'hFF, 1'b1, 1'b1);
   endtask

   task automatic test_address_byte;
      // The first command runs at the half period left by reset.
      send_word(OP_STOP, 7'h7F, 1'b1, 8'h00, 1'b0, 1'b0);
      finish_command(0, 1'b0, 0);
      set_half_period(16'd1);
      send_word(OP_START, 7'h7F, 1'b1, 8'h00, 1'b0, 1'b0);
      finish_command(0, 1'b0, 0);
      send_word(OP_START, 7'h00, 1'b0, 8'hFF, 1'b1, 1'b1);
      finish_command(0, 1'b1, 0);
   endtask

   task automatic test_data_bytes;
      send_word(OP_WRITE, 7'h00, 1'b0, 8'hFF, 1'b1, 1'b1);
      finish_command(0, 1'b0, 0);
      send_word(OP_WRITE, 7'h7F, 1'b1, 8'h00, 1'b0, 1'b0);
      finish_command(0, 1'b1, 0);
      send_word(OP_WRITE, 7'h2A, 1'b0, 8'hA5, 1'b1, 1'b0);
      finish_command(0, 1'b0, 0);
      send_word(OP_STOP, 7'h55, 1'b1, 8'h5A, 1'b0, 1'b1);
      finish_command(0, 1'b0, 0);
   endtask

   task automatic test_write_without_start;
      send_word(OP_WRITE, 7'h11, 1'b0, 8'h5A, 1'b1, 1'b1);
      finish_command(0, 1'b0, 0);
      send_word(OP_STOP, 7'h22, 1'b0, 8'h00, 1'b1, 1'b1);
      finish_command(0, 1'b0, 0);
   endtask

   task automatic test_missing_start;
      send_word(OP_START, 7'h55, 1'b0, 8'h00, 1'b1, 1'b1);
      while (line_phase == PH_START_HOLD)
         send_word(OP_TICK, 7'h2A, 1'b1, 8'hFF, scl_drive, 1'b1);
      finish_command(0, 1'b0, 0);
   endtask

   task automatic test_missing_stop;
      // SDA never read low during the high half before release.
      send_word(OP_STOP, 7'h01, 1'b0, 8'h01, 1'b1, 1'b1);
      while (line_phase != PH_STOP_HIGH)
         send_tick(0, 1'b0, 0);
      while (line_phase == PH_STOP_HIGH)
         send_word(OP_TICK, 7'h40, 1'b0, 8'h80, scl_drive, 1'b1);
      finish_command(0, 1'b0, 0);
      // SDA still reads low on the tick after its release.
      send_word(OP_STOP, 7'h02, 1'b1, 8'h02, 1'b0, 1'b0);
      while (line_phase != PH_STOP_CHECK)
         send_tick(0, 1'b0, 0);
      send_word(OP_TICK, 7'h03, 1'b0, 8'h03, 1'b1, 1'b0);
   endtask

   task automatic test_busy_commands;
      send_word(OP_START, 7'h12, 1'b0, 8'h00, 1'b1, 1'b0);
      repeat (3) send_tick(0, 1'b0, 0);
      send_random_word(OP_START);
      send_random_word(OP_WRITE);
      send_random_word(OP_STOP);
      finish_command(0, 1'b0, 0);
   endtask

   task automatic test_clock_stretch;
      send_word(OP_WRITE, 7'h33, 1'b1, 8'h3C, 1'b1, 1'b1);
      finish_command(70, 1'b0, 0);
   endtask

   task automatic test_zero_half_period;
      set_half_period(16'd0);
      send_word(OP_START, 7'h5A, 1'b1, 8'h00, 1'b1, 1'b0);
      finish_command(20, 1'b0, 0);
      send_word(OP_WRITE, 7'h00, 1'b0, 8'hC3, 1'b1, 1'b1);
      finish_command(0, 1'b1, 0);
      send_word(OP_STOP, 7'h00, 1'b0, 8'h00, 1'b1, 1'b1);
      finish_command(0, 1'b0, 0);
   endtask

   task automatic test_long_half_period;
      set_half_period(16'd24);
      send_word(OP_STOP, 7'h7F, 1'b1, 8'hFF, 1'b1, 1'b1);
      finish_command(1, 1'b0, 0);
   endtask

   task automatic run_random_command;
      int   stretch_pct;
      int   noise_pct;
      logic nack;
      nack        = ($urandom_range(0, 9) == 0);
      stretch_pct = ($urandom_range(0, 9) == 0) ? 40 : 0;
      noise_pct   = ($urandom_range(0, 9) == 0) ? 5 : 0;
      while (line_phase != PH_IDLE) begin
         if ($urandom_range(0, 49) == 0)
            send_random_word(2'($urandom_range(0, 2)));
         else
            send_tick(stretch_pct, nack, noise_pct);
      end
   endtask

   task automatic random_transfer;
      int pick;
      int bytes;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         send_random_word(OP_START);
         run_random_command;
         bytes = $urandom_range(0, 3);
         repeat (bytes) begin
            send_random_word(OP_WRITE);
            run_random_command;
         end
         send_random_word(OP_STOP);
         run_random_command;
      end else if (pick < 75) begin
         send_random_word(2'($urandom_range(1, 2)));
         run_random_command;
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 8))
            send_random_word(2'($urandom));
      end else begin
         // A start followed by garbage on the lines before normal ticks resume.
         send_random_word(OP_START);
         repeat ($urandom_range(1, 10))
            send_tick(0, 1'($urandom), 100);
         run_random_command;
      end
   endtask

   task automatic test_random_traffic;
      int target;
      for (int round = 0; round < 4; round++) begin
         set_half_period((round == 3) ? 16'($urandom_range(1, 8)) : 16'($urandom_range(1, 4)));
         steady = (round == 1);
         target = live_items + 25;
         while (live_items < target)
            random_transfer;
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      bus_view_type got_view;
      bus_view_type want_view;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_view = {rsp_scl_release, rsp_sda_release, rsp_busy_res, rsp_done_res, rsp_status};
         if (expected_views.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: response word with none expected: ",
                         "scl=%b sda=%b busy=%b done=%b status=%0d"},
                        $realtime, got_view.scl, got_view.sda, got_view.busy, got_view.done,
                        got_view.status);
         end else begin
            want_view = expected_views.pop_front();
            if (got_view !== want_view) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: expected scl=%b sda=%b busy=%b done=%b status=%0d, ",
                            "got scl=%b sda=%b busy=%b done=%b status=%0d"},
                           $realtime, want_view.scl, want_view.sda, want_view.busy,
                           want_view.done, want_view.status, got_view.scl, got_view.sda,
                           got_view.busy, got_view.done, got_view.status);
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_lines;
      test_address_byte;
      test_data_bytes;
      test_write_without_start;
      test_missing_start;
      test_missing_stop;
      test_busy_commands;
      test_clock_stretch;
      test_zero_half_period;
      test_long_half_period;
      test_random_traffic;
      req_valid <= 1'b0;
      while (expected_views.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("i2c_master_write_engine_tb passed");
      else
         $display("i2c_master_write_engine_tb failed");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("i2c_master_write_engine_tb failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/i2cmw_pkg.sv
hw/rtl/i2cmw_front.sv
hw/rtl/i2cmw_fifo.sv
hw/rtl/i2cmw_engine.sv
hw/rtl/i2c_master_write_engine.sv
test/i2c_master_write_engine_tb.sv
